/* hw/rtl/ptseq_pkg.sv */
`timescale 1ns / 1ps
// Package for the PWM tone sequencer: command codes, limits and the sound-effect ROM.
// Used by pwm_tone_sequencer; depends on nothing.
package ptseq_pkg;

  localparam logic [1:0] OPC_TICK   = 2'd0;
  localparam logic [1:0] OPC_TONE   = 2'd1;
  localparam logic [1:0] OPC_EFFECT = 2'd2;

  localparam logic [31:0] SYS_CLOCK_RESET = 32'd150000000;

  localparam int NUM_EFFECTS = 8;
  localparam int MAX_STEPS   = 4;
  localparam int DIVIDER_MAX = 256;
  localparam int TOP_MAX     = 65535;

  localparam int ROM_EFFECTS = 8;
  localparam int ROM_STEPS   = 4;

  localparam logic [15:0] ROM_FREQ [ROM_EFFECTS][ROM_STEPS] = '{
    '{16'd760, 16'd980,  16'd0,    16'd0},
    '{16'd900, 16'd1160, 16'd1460, 16'd0},
    '{16'd420, 16'd320,  16'd0,    16'd0},
    '{16'd520, 16'd430,  16'd330,  16'd240},
    '{16'd330, 16'd392,  16'd0,    16'd0},
    '{16'd420, 16'd500,  16'd600,  16'd0},
    '{16'd440, 16'd520,  16'd620,  16'd0},
    '{16'd220, 16'd180,  16'd150,  16'd0}
  };

  localparam logic [15:0] ROM_MS [ROM_EFFECTS][ROM_STEPS] = '{
    '{16'd22, 16'd22, 16'd0,  16'd0},
    '{16'd38, 16'd38, 16'd46, 16'd0},
    '{16'd45, 16'd35, 16'd0,  16'd0},
    '{16'd70, 16'd70, 16'd90, 16'd130},
    '{16'd12, 16'd14, 16'd0,  16'd0},
    '{16'd18, 16'd20, 16'd22, 16'd0},
    '{16'd16, 16'd18, 16'd22, 16'd0},
    '{16'd18, 16'd22, 16'd28, 16'd0}
  };

  localparam logic [2:0] ROM_LEN [ROM_EFFECTS] = '{
    3'd2, 3'd3, 3'd2, 3'd4, 3'd2, 3'd3, 3'd3, 3'd3
  };

  function automatic logic [2:0] effect_length(input logic [2:0] e);
    logic [2:0] n;
    n = ROM_LEN[e];
    if (int'(n) > MAX_STEPS) n = 3'(MAX_STEPS);
    if (int'(n) > ROM_STEPS) n = 3'(ROM_STEPS);
    return n;
  endfunction

endpackage

/* hw/rtl/pwm_tone_sequencer.sv */
`timescale 1ns / 1ps
// Top level of the PWM tone sequencer: command decode, effect stepping and PWM set-up
// through one shared restoring divider. Depends on ptseq_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall): one command per transaction - a millisecond
//   tick, a one-shot tone or a sound effect. in_stall is high while a command is
//   being worked on; the block takes one command at a time.
//   Output channel (out_valid / out_stall): exactly one result per command, giving
//   the PWM enable, divider, top, duty level and effect-running flag after the update.
//   Config channel (cfg_valid / cfg_ready): writes the system clock frequency in Hz;
//   always ready, write only while no command is in flight.
//   A command that starts a tone runs through S_SCALE, two 32-step passes of the shared
//   divider (one for the divider choice, one for the wrap value) with S_PICK and S_MUL2
//   between them, then S_FIN and S_DONE; any other command goes straight to S_DONE.
//   The next command is accepted in the cycle after the result is loaded in the output
//   register, even while out_stall holds that result; a finished result waits for a free
//   output register before the block returns to idle.
//   Reset (rst_n low, synchronous): silent, no effect running, divider/top/level 1,
//   system clock 150 MHz, output register empty.
module pwm_tone_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [15:0] in_tone_frequency,
  input  logic [15:0] in_tone_duration,
  input  logic [2:0]  in_effect_id,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_pwm_enable,
  output logic [8:0]  out_clk_divider,
  output logic [15:0] out_pwm_top,
  output logic [14:0] out_duty_level,
  output logic        out_sequence_busy
);

  typedef enum logic [2:0] {
    S_IDLE, S_SCALE, S_DIV, S_PICK, S_MUL2, S_FIN, S_DONE
  } state_t;

  localparam logic [16:0] TOP_PLUS1 = 17'(ptseq_pkg::TOP_MAX + 1);
  localparam logic [15:0] TOP_SAT   = 16'(ptseq_pkg::TOP_MAX);
  localparam logic [14:0] LVL_SAT   = 15'(ptseq_pkg::TOP_MAX / 2);

  state_t      state_r, state_nxt;
  logic [31:0] sys_clk_r, sys_clk_nxt;
  logic        tone_on_r, tone_on_nxt;
  logic        seq_on_r, seq_on_nxt;
  logic [2:0]  effect_r, effect_nxt;
  logic [2:0]  step_r, step_nxt;
  logic [15:0] ms_r, ms_nxt;
  logic [8:0]  div_r, div_nxt;
  logic [15:0] top_r, top_nxt;
  logic [14:0] lvl_r, lvl_nxt;

  logic [15:0] freq_r, freq_nxt;
  logic [15:0] dur_r, dur_nxt;
  logic [31:0] den_r, den_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        second_r, second_nxt;
  logic [8:0]  divc_r, divc_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic        out_en_r, out_en_nxt;
  logic [8:0]  out_div_r, out_div_nxt;
  logic [15:0] out_top_r, out_top_nxt;
  logic [14:0] out_lvl_r, out_lvl_nxt;
  logic        out_busy_r, out_busy_nxt;

  always_comb begin
    logic        tone_req;
    logic [15:0] req_freq;
    logic [15:0] req_dur;
    logic [3:0]  step_inc;
    logic [2:0]  len_cur;
    logic [2:0]  len_new;
    logic        effect_ok;
    logic [32:0] trial;
    logic [32:0] diff;
    logic        ge;
    logic [31:0] wrap;
    logic [31:0] top32;
    logic [31:0] lvl32;

    state_nxt     = state_r;
    sys_clk_nxt   = sys_clk_r;
    tone_on_nxt   = tone_on_r;
    seq_on_nxt    = seq_on_r;
    effect_nxt    = effect_r;
    step_nxt      = step_r;
    ms_nxt        = ms_r;
    div_nxt       = div_r;
    top_nxt       = top_r;
    lvl_nxt       = lvl_r;
    freq_nxt      = freq_r;
    dur_nxt       = dur_r;
    den_nxt       = den_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    second_nxt    = second_r;
    divc_nxt      = divc_r;
    out_valid_nxt = out_valid_r;
    out_en_nxt    = out_en_r;
    out_div_nxt   = out_div_r;
    out_top_nxt   = out_top_r;
    out_lvl_nxt   = out_lvl_r;
    out_busy_nxt  = out_busy_r;

    tone_req  = 1'b0;
    req_freq  = '0;
    req_dur   = '0;
    step_inc  = {1'b0, step_r} + 4'd1;
    len_cur   = ptseq_pkg::effect_length(effect_r);
    len_new   = ptseq_pkg::effect_length(in_effect_id);
    effect_ok = (int'(in_effect_id) < ptseq_pkg::NUM_EFFECTS) &&
                (int'(in_effect_id) < ptseq_pkg::ROM_EFFECTS) && (len_new != 3'd0);
    trial     = {rem_r, quo_r[31]};
    diff      = trial - {1'b0, den_r};
    ge        = (trial >= {1'b0, den_r});
    wrap      = (quo_r < 32'd2) ? 32'd2 : quo_r;
    top32     = wrap - 32'd1;
    lvl32     = wrap >> 1;

    if (cfg_valid) begin
      sys_clk_nxt = cfg_data;
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_DONE;
          unique case (in_opcode)
            ptseq_pkg::OPC_TICK: begin
              if (tone_on_r) begin
                if (ms_r > 16'd1) begin
                  ms_nxt = ms_r - 16'd1;
                end else begin
                  ms_nxt = '0;
                  if (!seq_on_r) begin
                    tone_on_nxt = 1'b0;
                  end else if (step_inc < {1'b0, len_cur}) begin
                    step_nxt = step_inc[2:0];
                    tone_req = 1'b1;
                    req_freq = ptseq_pkg::ROM_FREQ[effect_r][step_inc[1:0]];
                    req_dur  = ptseq_pkg::ROM_MS[effect_r][step_inc[1:0]];
                  end else begin
                    seq_on_nxt  = 1'b0;
                    tone_on_nxt = 1'b0;
                  end
                end
              end
            end
            ptseq_pkg::OPC_TONE: begin
              seq_on_nxt = 1'b0;
              tone_req   = 1'b1;
              req_freq   = in_tone_frequency;
              req_dur    = in_tone_duration;
            end
            ptseq_pkg::OPC_EFFECT: begin
              if (effect_ok) begin
                effect_nxt = in_effect_id;
                step_nxt   = 3'd0;
                seq_on_nxt = 1'b1;
                tone_req   = 1'b1;
                req_freq   = ptseq_pkg::ROM_FREQ[in_effect_id][0];
                req_dur    = ptseq_pkg::ROM_MS[in_effect_id][0];
              end
            end
            default: begin
            end
          endcase
          if (tone_req) begin
            if (req_freq == 16'd0 || req_dur == 16'd0) begin
              tone_on_nxt = 1'b0;
            end else begin
              freq_nxt  = req_freq;
              dur_nxt   = req_dur;
              state_nxt = S_SCALE;
            end
          end
        end
      end
      S_SCALE: begin
        den_nxt    = 32'(freq_r * TOP_PLUS1);
        quo_nxt    = sys_clk_r;
        rem_nxt    = '0;
        cnt_nxt    = '1;
        second_nxt = 1'b0;
        state_nxt  = S_DIV;
      end
      S_DIV: begin
        rem_nxt = ge ? diff[31:0] : trial[31:0];
        quo_nxt = {quo_r[30:0], ge};
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          state_nxt = second_r ? S_FIN : S_PICK;
        end
      end
      S_PICK: begin
        if (quo_r >= 32'(ptseq_pkg::DIVIDER_MAX)) begin
          divc_nxt = 9'(ptseq_pkg::DIVIDER_MAX);
        end else begin
          divc_nxt = quo_r[8:0] + 9'd1;
        end
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        den_nxt    = 32'(freq_r * divc_r);
        quo_nxt    = sys_clk_r;
        rem_nxt    = '0;
        cnt_nxt    = '1;
        second_nxt = 1'b1;
        state_nxt  = S_DIV;
      end
      S_FIN: begin
        div_nxt     = divc_r;
        top_nxt     = (top32 > 32'(ptseq_pkg::TOP_MAX)) ? TOP_SAT : top32[15:0];
        lvl_nxt     = (lvl32 > 32'(ptseq_pkg::TOP_MAX / 2)) ? LVL_SAT : lvl32[14:0];
        ms_nxt      = dur_r;
        tone_on_nxt = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_en_nxt    = tone_on_r;
          out_div_nxt   = div_r;
          out_top_nxt   = top_r;
          out_lvl_nxt   = lvl_r;
          out_busy_nxt  = seq_on_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sys_clk_r   <= ptseq_pkg::SYS_CLOCK_RESET;
      tone_on_r   <= 1'b0;
      seq_on_r    <= 1'b0;
      effect_r    <= '0;
      step_r      <= '0;
      ms_r        <= '0;
      div_r       <= 9'd1;
      top_r       <= 16'd1;
      lvl_r       <= 15'd1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sys_clk_r   <= sys_clk_nxt;
      tone_on_r   <= tone_on_nxt;
      seq_on_r    <= seq_on_nxt;
      effect_r    <= effect_nxt;
      step_r      <= step_nxt;
      ms_r        <= ms_nxt;
      div_r       <= div_nxt;
      top_r       <= top_nxt;
      lvl_r       <= lvl_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    freq_r     <= freq_nxt;
    dur_r      <= dur_nxt;
    den_r      <= den_nxt;
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    cnt_r      <= cnt_nxt;
    second_r   <= second_nxt;
    divc_r     <= divc_nxt;
    out_en_r   <= out_en_nxt;
    out_div_r  <= out_div_nxt;
    out_top_r  <= out_top_nxt;
    out_lvl_r  <= out_lvl_nxt;
    out_busy_r <= out_busy_nxt;
  end

  assign cfg_ready         = 1'b1;
  assign in_stall          = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_pwm_enable    = out_en_r;
  assign out_clk_divider   = out_div_r;
  assign out_pwm_top       = out_top_r;
  assign out_duty_level    = out_lvl_r;
  assign out_sequence_busy = out_busy_r;

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for pwm_tone_sequencer: directed table, then random command
// streams under several system clock settings, checked against table values or an
// in-bench tone model. Depends on ptseq_pkg and pwm_tone_sequencer.
module testbench;

  localparam logic [1:0] OPC_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 80;
  localparam int PHASE_ITEMS = 210;

  typedef struct packed {
    logic        pwm_enable;
    logic [8:0]  clk_divider;
    logic [15:0] pwm_top;
    logic [14:0] duty_level;
    logic        sequence_busy;
  } pwm_setting_t;

  typedef struct packed {
    logic         is_clock;
    logic [31:0]  clock_hz;
    logic [1:0]   op;
    logic [15:0]  freq;
    logic [15:0]  dur;
    logic [2:0]   eid;
    logic         typed;
    pwm_setting_t want;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_opcode;
  logic [15:0] in_tone_frequency;
  logic [15:0] in_tone_duration;
  logic [2:0]  in_effect_id;
  logic        out_valid;
  logic        out_stall;
  logic        out_pwm_enable;
  logic [8:0]  out_clk_divider;
  logic [15:0] out_pwm_top;
  logic [14:0] out_duty_level;
  logic        out_sequence_busy;

  pwm_tone_sequencer dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_tone_frequency (in_tone_frequency),
    .in_tone_duration  (in_tone_duration),
    .in_effect_id      (in_effect_id),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_pwm_enable    (out_pwm_enable),
    .out_clk_divider   (out_clk_divider),
    .out_pwm_top       (out_pwm_top),
    .out_duty_level    (out_duty_level),
    .out_sequence_busy (out_sequence_busy)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Tone model state
  logic [31:0] sim_clock_hz;
  logic        sim_tone_on;
  logic        sim_in_effect;
  logic [2:0]  sim_effect;
  logic [2:0]  sim_step;
  logic [15:0] sim_ms_left;
  logic [8:0]  sim_div;
  logic [15:0] sim_top;
  logic [14:0] sim_level;

  pwm_setting_t pending_settings[$];
  row_t         script[$];

  int n_errors = 0;
  int n_commands = 0;
  int n_items = 0;
  int n_results = 0;
  int n_tones = 0;
  int n_effects_done = 0;
  int n_clocks = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  int stall_count = 0;
  int stall_mode = 0;

  function automatic int steps_in_effect(input logic [2:0] e);
    int n;
    n = int'(ptseq_pkg::ROM_LEN[e]);
    if (n > ptseq_pkg::MAX_STEPS) n = ptseq_pkg::MAX_STEPS;
    if (n > ptseq_pkg::ROM_STEPS) n = ptseq_pkg::ROM_STEPS;
    return n;
  endfunction

  function automatic void load_tone(input logic [15:0] f, input logic [15:0] d);
    logic [31:0] div;
    logic [31:0] wrap;
    logic [31:0] top;
    logic [31:0] lvl;
    if (f == '0 || d == '0) begin
      sim_tone_on = 1'b0;
      return;
    end
    div = 32'd1;
    wrap = sim_clock_hz / {16'd0, f};
    while (wrap > 32'(ptseq_pkg::TOP_MAX) && div < 32'(ptseq_pkg::DIVIDER_MAX)) begin
      div = div + 32'd1;
      wrap = sim_clock_hz / ({16'd0, f} * div);
    end
    if (wrap < 32'd2) wrap = 32'd2;
    top = wrap - 32'd1;
    if (top > 32'(ptseq_pkg::TOP_MAX)) top = 32'(ptseq_pkg::TOP_MAX);
    lvl = wrap / 32'd2;
    if (lvl > 32'(ptseq_pkg::TOP_MAX / 2)) lvl = 32'(ptseq_pkg::TOP_MAX / 2);
    sim_div = div[8:0];
    sim_top = top[15:0];
    sim_level = lvl[14:0];
    sim_ms_left = d;
    sim_tone_on = 1'b1;
    n_tones++;
  endfunction

  function automatic pwm_setting_t apply_command(input logic [1:0] op, input logic [15:0] f,
                                                 input logic [15:0] d, input logic [2:0] e);
    int s;
    pwm_setting_t r;
    case (op)
      ptseq_pkg::OPC_TICK: begin
        if (sim_tone_on) begin
          if (sim_ms_left > 16'd1) begin
            sim_ms_left = sim_ms_left - 16'd1;
          end else begin
            sim_ms_left = '0;
            if (!sim_in_effect) begin
              sim_tone_on = 1'b0;
            end else begin
              s = int'(sim_step) + 1;
              if (s < steps_in_effect(sim_effect)) begin
                sim_step = 3'(s);
                load_tone(ptseq_pkg::ROM_FREQ[sim_effect][s],
                          ptseq_pkg::ROM_MS[sim_effect][s]);
              end else begin
                sim_in_effect = 1'b0;
                sim_tone_on = 1'b0;
                n_effects_done++;
              end
            end
          end
        end
      end
      ptseq_pkg::OPC_TONE: begin
        sim_in_effect = 1'b0;
        load_tone(f, d);
      end
      ptseq_pkg::OPC_EFFECT: begin
        if (int'(e) < ptseq_pkg::NUM_EFFECTS && int'(e) < ptseq_pkg::ROM_EFFECTS &&
            steps_in_effect(e) > 0) begin
          sim_effect = e;
          sim_step = '0;
          sim_in_effect = 1'b1;
          load_tone(ptseq_pkg::ROM_FREQ[e][0], ptseq_pkg::ROM_MS[e][0]);
        end
      end
      default: ;
    endcase
    r.pwm_enable = sim_tone_on;
    r.clk_divider = sim_div;
    r.pwm_top = sim_top;
    r.duty_level = sim_level;
    r.sequence_busy = sim_in_effect;
    return r;
  endfunction

  function automatic row_t row_cmd(input logic [1:0] op, input logic [15:0] f,
                                   input logic [15:0] d, input logic [2:0] e);
    row_t r;
    r = '0;
    r.op = op;
    r.freq = f;
    r.dur = d;
    r.eid = e;
    return r;
  endfunction

  function automatic row_t row_known(input logic [1:0] op, input logic [15:0] f,
                                     input logic [15:0] d, input logic [2:0] e,
                                     input logic en, input logic [8:0] dv,
                                     input logic [15:0] tp, input logic [14:0] lv,
                                     input logic busy);
    row_t r;
    r = row_cmd(op, f, d, e);
    r.typed = 1'b1;
    r.want = '{en, dv, tp, lv, busy};
    return r;
  endfunction

  function automatic row_t row_clock(input logic [31:0] hz);
    row_t r;
    r = '0;
    r.is_clock = 1'b1;
    r.clock_hz = hz;
    return r;
  endfunction

  task automatic send_command(input logic [1:0] op, input logic [15:0] f,
                              input logic [15:0] d, input logic [2:0] e,
                              input logic typed, input pwm_setting_t want);
    int gap;
    pwm_setting_t got;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 8);
    end
    burst_left--;
    in_opcode <= op;
    in_tone_frequency <= f;
    in_tone_duration <= d;
    in_effect_id <= e;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    got = apply_command(op, f, d, e);
    pending_settings.push_back(typed ? want : got);
    n_commands++;
    if (op != OPC_UNUSED) n_items++;
  endtask

  task automatic issue(input logic [1:0] op, input logic [15:0] f, input logic [15:0] d,
                       input logic [2:0] e);
    send_command(op, f, d, e, 1'b0, '0);
  endtask

  task automatic run_ticks(input int n);
    repeat (n) issue(ptseq_pkg::OPC_TICK, 16'($urandom), 16'($urandom), 3'($urandom));
  endtask

  task automatic write_clock(input logic [31:0] hz);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_settings.size() != 0) @(posedge clk);
    @(posedge clk);
    cfg_data <= hz;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sim_clock_hz = hz;
    n_clocks++;
  endtask

  task automatic random_phase(input int budget);
    int start;
    int kind;
    int e;
    int k;
    int total;
    int n;
    logic [15:0] f;
    logic [15:0] d;
    start = n_items;
    while (n_items - start < budget) begin
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
        e = $urandom_range(0, 7);
        total = 0;
        for (k = 0; k < steps_in_effect(3'(e)); k++) total += int'(ptseq_pkg::ROM_MS[e][k]);
        issue(ptseq_pkg::OPC_EFFECT, 16'($urandom), 16'($urandom), 3'(e));
        if ($urandom_range(0, 1) == 0 && (e != 3 || $urandom_range(0, 3) == 0))
          n = total + $urandom_range(0, 3);
        else
          n = $urandom_range(0, (total < 80) ? total : 80);
        run_ticks(n);
      end else if (kind < 7) begin
        case ($urandom_range(0, 3))
          0: f = 16'($urandom_range(1, 64));
          1: f = 16'($urandom_range(65000, 65535));
          default: f = 16'($urandom);
        endcase
        case ($urandom_range(0, 9))
          0: d = '0;
          1: d = 16'($urandom);
          default: d = 16'($urandom_range(1, 6));
        endcase
        issue(ptseq_pkg::OPC_TONE, f, d, 3'($urandom));
        run_ticks($urandom_range(0, (d < 16'd8) ? int'(d) + 1 : 9));
      end else begin
        issue(2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom), 3'($urandom));
      end
    end
  endtask

  function automatic void compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endfunction

  always @(posedge clk) begin
    stall_count <= stall_count + 1;
    if (stall_count % 64 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 2) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= stall_count[3];
    endcase
  end

  always @(posedge clk) begin
    pwm_setting_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_settings.size() == 0) begin
        $error("result transaction with no command pending");
        n_errors++;
      end else begin
        want = pending_settings.pop_front();
        compare_field("pwm_enable", want.pwm_enable, out_pwm_enable);
        compare_field("clk_divider", want.clk_divider, out_clk_divider);
        compare_field("pwm_top", want.pwm_top, out_pwm_top);
        compare_field("duty_level", want.duty_level, out_duty_level);
        compare_field("sequence_busy", want.sequence_busy, out_sequence_busy);
        n_results++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
    $display("Verification failed");
    $finish;
  end

  initial begin
    logic [31:0] clock_plan [5];
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_opcode = '0;
    in_tone_frequency = '0;
    in_tone_duration = '0;
    in_effect_id = '0;

    sim_clock_hz = ptseq_pkg::SYS_CLOCK_RESET;
    sim_tone_on = 1'b0;
    sim_in_effect = 1'b0;
    sim_effect = '0;
    sim_step = '0;
    sim_ms_left = '0;
    sim_div = 9'd1;
    sim_top = 16'd1;
    sim_level = 15'd1;

    script = '{
      row_known(ptseq_pkg::OPC_TICK, 16'd0, 16'd0, 3'd0,
                1'b0, 9'd1, 16'd1, 15'd1, 1'b0),
      row_known(OPC_UNUSED, 16'hFFFF, 16'hFFFF, 3'd7,
                1'b0, 9'd1, 16'd1, 15'd1, 1'b0),
      row_known(ptseq_pkg::OPC_TONE, 16'd0, 16'd100, 3'd0,
                1'b0, 9'd1, 16'd1, 15'd1, 1'b0),
      row_known(ptseq_pkg::OPC_TONE, 16'd440, 16'd0, 3'd5,
                1'b0, 9'd1, 16'd1, 15'd1, 1'b0),
      row_known(ptseq_pkg::OPC_TONE, 16'd65535, 16'd2, 3'd0,
                1'b1, 9'd1, 16'd2287, 15'd1144, 1'b0),
      row_known(ptseq_pkg::OPC_TICK, 16'd0, 16'd0, 3'd0,
                1'b1, 9'd1, 16'd2287, 15'd1144, 1'b0),
      row_known(ptseq_pkg::OPC_TICK, 16'd0, 16'd0, 3'd0,
                1'b0, 9'd1, 16'd2287, 15'd1144, 1'b0),
      row_known(ptseq_pkg::OPC_TICK, 16'hFFFF, 16'hFFFF, 3'd7,
                1'b0, 9'd1, 16'd2287, 15'd1144, 1'b0),
      row_known(ptseq_pkg::OPC_TONE, 16'd1, 16'd1, 3'd0,
                1'b1, 9'd256, 16'd65535, 15'd32767, 1'b0),
      row_known(ptseq_pkg::OPC_TICK, 16'd0, 16'd0, 3'd0,
                1'b0, 9'd256, 16'd65535, 15'd32767, 1'b0),
      row_cmd(ptseq_pkg::OPC_EFFECT, 16'd0, 16'd0, 3'd0),
      row_cmd(ptseq_pkg::OPC_TICK, 16'd0, 16'd0, 3'd0),
      row_cmd(ptseq_pkg::OPC_TONE, 16'd1000, 16'd5, 3'd2),
      row_cmd(ptseq_pkg::OPC_EFFECT, 16'hFFFF, 16'hFFFF, 3'd3),
      row_cmd(OPC_UNUSED, 16'd1234, 16'd5678, 3'd1),
      row_cmd(ptseq_pkg::OPC_EFFECT, 16'd0, 16'd0, 3'd7),
      row_clock(32'd1000),
      row_known(ptseq_pkg::OPC_TONE, 16'd65535, 16'd1, 3'd0,
                1'b1, 9'd1, 16'd1, 15'd1, 1'b0),
      row_known(ptseq_pkg::OPC_TICK, 16'd0, 16'd0, 3'd0,
                1'b0, 9'd1, 16'd1, 15'd1, 1'b0),
      row_cmd(ptseq_pkg::OPC_TONE, 16'd500, 16'd3, 3'd0),
      row_clock(32'hFFFF_FFFF),
      row_known(ptseq_pkg::OPC_TONE, 16'd1, 16'd65535, 3'd0,
                1'b1, 9'd256, 16'd65535, 15'd32767, 1'b0),
      row_known(ptseq_pkg::OPC_TONE, 16'd65535, 16'd1, 3'd4,
                1'b1, 9'd2, 16'd32767, 15'd16384, 1'b0),
      row_cmd(ptseq_pkg::OPC_EFFECT, 16'd0, 16'd0, 3'd4)
    };

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].is_clock)
        write_clock(script[i].clock_hz);
      else
        send_command(script[i].op, script[i].freq, script[i].dur, script[i].eid,
                     script[i].typed, script[i].want);
    end

    clock_plan = '{ptseq_pkg::SYS_CLOCK_RESET, 32'd1000, 32'hFFFF_FFFF,
                   32'($urandom_range(1000, 50000000)), $urandom | 32'd1000};
    foreach (clock_plan[p]) begin
      write_clock(clock_plan[p]);
      random_phase(PHASE_ITEMS);
    end

    in_valid <= 1'b0;
    while (pending_settings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d commands: %0d tone set-ups, %0d effects played out, %0d clock settings",
             n_commands, n_tones, n_effects_done, n_clocks);
    $display("Checked %0d results, %0d mismatches", n_results, n_errors);
    if (n_errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/ptseq_pkg.sv
hw/rtl/pwm_tone_sequencer.sv
dv/testbench.sv
